### src/adjacency_matrix_graph_traversal_unit_macros.svh
// ----------------------------------------------------------------------------
// Graph traversal unit assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_GRAPH_TRAVERSAL_UNIT_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_TRAVERSAL_UNIT_MACROS_SVH

// property that must hold at every edge
`define AMGT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// antecedent followed by consequent in the cycle after
`define AMGT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/amgt_pkg.sv
// ----------------------------------------------------------------------------
// Graph traversal unit package
// Widths, operation codes and controller state codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amgt_pkg;

  localparam int MaxNodes   = 64;
  localparam int NodeW      = 6;
  localparam int CountW     = 7;
  localparam int WeightW    = 32;
  localparam int ListW      = NodeW + CountW;

  localparam logic [CountW-1:0] NODE_LIMIT = 7'd64;

  // operation codes
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_FIND   = 3'd1;
  localparam logic [2:0] KIND_BFS    = 3'd2;
  localparam logic [2:0] KIND_DFS    = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // controller states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INS   = 4'd1;
  localparam logic [3:0] S_FIND  = 4'd2;
  localparam logic [3:0] S_BAD   = 4'd3;
  localparam logic [3:0] S_ROWRD = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_POPW  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

endpackage

### src/amgt_in_if.sv
// ----------------------------------------------------------------------------
// Graph command channel
// Valid/ready channel carrying one command per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface amgt_in_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         kind;
  logic [amgt_pkg::NodeW-1:0]         from_node;
  logic [amgt_pkg::NodeW-1:0]         to_node;
  logic signed [amgt_pkg::WeightW-1:0] edge_weight;

  modport source (output valid, kind, from_node, to_node, edge_weight, input ready);
  modport sink   (input valid, kind, from_node, to_node, edge_weight, output ready);
endinterface

### src/amgt_out_if.sv
// ----------------------------------------------------------------------------
// Graph result channel
// Valid/ready channel carrying one result per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface amgt_out_if;
  logic                               valid;
  logic                               ready;
  logic [amgt_pkg::NodeW-1:0]         visited_node;
  logic                               edge_found;
  logic signed [amgt_pkg::WeightW-1:0] found_weight;
  logic                               bad_start;
  logic                               last;

  modport source (output valid, visited_node, edge_found, found_weight, bad_start, last,
                  input ready);
  modport sink   (input valid, visited_node, edge_found, found_weight, bad_start, last,
                  output ready);
endinterface

### src/adjacency_matrix_graph_traversal_unit.sv
// Insert: row read and weight write, then row write back; clear: done on acceptance;
// find: row and weight reads, then the result is registered once the output can take it.
// Traversal: a row read per visited vertex, one neighbour index checked per cycle
// unless a hit waits on the output, and a list read plus row re-read per return.
// One item is processed at a time. Reset: node_count 64, all row valid bits cleared.
// ----------------------------------------------------------------------------
// Adjacency matrix graph traversal unit
// Edge store, lookup, breadth first and depth first traversal over RAM
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adjacency_matrix_graph_traversal_unit_macros.svh"

module adjacency_matrix_graph_traversal_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  amgt_in_if.sink                     in_i,
  amgt_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [amgt_pkg::CountW-1:0] cfg_data_i
);

  localparam int MN = amgt_pkg::MaxNodes;
  localparam int NW = amgt_pkg::NodeW;
  localparam int CW = amgt_pkg::CountW;
  localparam int WW = amgt_pkg::WeightW;
  localparam int LW = amgt_pkg::ListW;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] node_count_q;
  logic [MN-1:0] row_vld_q, row_vld_d;
  logic [MN-1:0] visited_q, visited_d;
  logic [NW-1:0] cmd_a_q, cmd_a_d, cmd_b_q, cmd_b_d;
  logic          dfs_q, dfs_d;
  logic [NW-1:0] cur_t_q, cur_t_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [NW-1:0] hold_q, hold_d;
  logic [CW-1:0] head_q, head_d, cnt_q, cnt_d;

  logic          out_vld_q, out_vld_d;
  logic [NW-1:0] o_node_q, o_node_d;
  logic          o_found_q, o_found_d, o_bad_q, o_bad_d, o_last_q, o_last_d;
  logic [WW-1:0] o_wt_q, o_wt_d;

  // ram ports
  logic           e_we, e_re;
  logic [NW-1:0]  e_waddr, e_raddr;
  logic [MN-1:0]  e_wdata, e_rdata;
  logic           w_we, w_re;
  logic [2*NW-1:0] w_waddr, w_raddr;
  logic [WW-1:0]  w_wdata, w_rdata;
  logic           l_we, l_re;
  logic [NW-1:0]  l_waddr, l_raddr;
  logic [LW-1:0]  l_wdata, l_rdata;

  logic [CW-1:0] n_act;
  logic          emit_ok, accept;
  logic          a_in, b_in;
  logic [MN-1:0] row_w;
  logic [NW-1:0] idx6;
  logic          hit, found;
  logic          in_scan, find_acc;

  amgt_ram #(.Width(MN), .Depth(MN)) u_edge_ram (
    .clk_i(clk_i), .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .re_i(e_re), .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  amgt_ram #(.Width(WW), .Depth(MN * MN)) u_weight_ram (
    .clk_i(clk_i), .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .re_i(w_re), .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  amgt_ram #(.Width(LW), .Depth(MN)) u_list_ram (
    .clk_i(clk_i), .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .re_i(l_re), .raddr_i(l_raddr), .rdata_o(l_rdata)
  );

  // active vertex count and helpers
  assign n_act   = (node_count_q > amgt_pkg::NODE_LIMIT) ? amgt_pkg::NODE_LIMIT : node_count_q;
  assign emit_ok = !out_vld_q || out_o.ready;
  assign accept  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == amgt_pkg::S_IDLE);
  assign a_in    = {1'b0, in_i.from_node} < n_act;
  assign b_in    = {1'b0, in_i.to_node} < n_act;
  assign row_w   = row_vld_q[cur_t_q] ? e_rdata : '0;
  assign idx6    = idx_q[NW-1:0];
  assign hit     = (idx_q < n_act) && row_w[idx6] && !visited_q[idx6] && (idx6 != cur_t_q);
  assign found   = ({1'b0, cmd_a_q} < n_act) && ({1'b0, cmd_b_q} < n_act) &&
                   (cmd_a_q != cmd_b_q) && row_vld_q[cmd_a_q] && e_rdata[cmd_b_q];
  assign in_scan  = (state_q == amgt_pkg::S_SCAN);
  assign find_acc = accept && (in_i.kind == amgt_pkg::KIND_FIND);

  // controller
  always_comb begin
    state_d   = state_q;
    row_vld_d = row_vld_q;
    visited_d = visited_q;
    cmd_a_d   = cmd_a_q;
    cmd_b_d   = cmd_b_q;
    dfs_d     = dfs_q;
    cur_t_d   = cur_t_q;
    idx_d     = idx_q;
    hold_d    = hold_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    out_vld_d = out_o.ready ? 1'b0 : out_vld_q;
    o_node_d  = o_node_q;
    o_found_d = o_found_q;
    o_wt_d    = o_wt_q;
    o_bad_d   = o_bad_q;
    o_last_d  = o_last_q;
    e_we = 1'b0; e_waddr = cmd_a_q; e_wdata = '0;
    e_re = 1'b0; e_raddr = cur_t_q;
    w_we = 1'b0; w_waddr = {in_i.from_node, in_i.to_node}; w_wdata = in_i.edge_weight;
    w_re = 1'b0; w_raddr = {in_i.from_node, in_i.to_node};
    l_we = 1'b0; l_waddr = cnt_q[NW-1:0]; l_wdata = '0;
    l_re = 1'b0; l_raddr = head_q[NW-1:0];

    case (state_q)
      amgt_pkg::S_IDLE: begin
        if (accept) begin
          cmd_a_d = in_i.from_node;
          cmd_b_d = in_i.to_node;
          case (in_i.kind)
            amgt_pkg::KIND_INSERT: begin
              if (a_in && b_in && (in_i.from_node != in_i.to_node)) begin
                e_re    = 1'b1;
                e_raddr = in_i.from_node;
                w_we    = 1'b1;
                state_d = amgt_pkg::S_INS;
              end
            end
            amgt_pkg::KIND_FIND: begin
              e_re    = 1'b1;
              e_raddr = in_i.from_node;
              w_re    = 1'b1;
              state_d = amgt_pkg::S_FIND;
            end
            amgt_pkg::KIND_BFS, amgt_pkg::KIND_DFS: begin
              if (!a_in) begin
                state_d = amgt_pkg::S_BAD;
              end else begin
                dfs_d     = (in_i.kind == amgt_pkg::KIND_DFS);
                visited_d = MN'(1) << in_i.from_node;
                hold_d    = in_i.from_node;
                cur_t_d   = in_i.from_node;
                idx_d     = '0;
                head_d    = '0;
                cnt_d     = '0;
                state_d   = amgt_pkg::S_ROWRD;
              end
            end
            amgt_pkg::KIND_CLEAR: begin
              row_vld_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      // merge the new destination bit into the row
      amgt_pkg::S_INS: begin
        e_we = 1'b1;
        e_wdata = (row_vld_q[cmd_a_q] ? e_rdata : '0) | (MN'(1) << cmd_b_q);
        row_vld_d[cmd_a_q] = 1'b1;
        state_d = amgt_pkg::S_IDLE;
      end
      amgt_pkg::S_FIND: begin
        if (emit_ok) begin
          out_vld_d = 1'b1;
          o_node_d  = '0;
          o_found_d = found;
          o_wt_d    = found ? w_rdata : '0;
          o_bad_d   = 1'b0;
          o_last_d  = 1'b1;
          state_d   = amgt_pkg::S_IDLE;
        end
      end
      amgt_pkg::S_BAD: begin
        if (emit_ok) begin
          out_vld_d = 1'b1;
          o_node_d  = '0;
          o_found_d = 1'b0;
          o_wt_d    = '0;
          o_bad_d   = 1'b1;
          o_last_d  = 1'b1;
          state_d   = amgt_pkg::S_IDLE;
        end
      end
      amgt_pkg::S_ROWRD: begin
        e_re    = 1'b1;
        state_d = amgt_pkg::S_SCAN;
      end
      // one neighbour index per cycle, unless a hit waits on the output
      amgt_pkg::S_SCAN: begin
        if (idx_q >= n_act) begin
          if (dfs_q) begin
            if (cnt_q != '0) begin
              l_re    = 1'b1;
              l_raddr = NW'(cnt_q - CW'(1));
              cnt_d   = cnt_q - CW'(1);
              state_d = amgt_pkg::S_POPW;
            end else begin
              state_d = amgt_pkg::S_FIN;
            end
          end else if (head_q < cnt_q) begin
            l_re    = 1'b1;
            head_d  = head_q + CW'(1);
            state_d = amgt_pkg::S_POPW;
          end else begin
            state_d = amgt_pkg::S_FIN;
          end
        end else if (hit) begin
          if (emit_ok) begin
            out_vld_d = 1'b1;
            o_node_d  = hold_q;
            o_found_d = 1'b0;
            o_wt_d    = '0;
            o_bad_d   = 1'b0;
            o_last_d  = 1'b0;
            hold_d    = idx6;
            visited_d = visited_q | (MN'(1) << idx6);
            l_we      = 1'b1;
            cnt_d     = cnt_q + CW'(1);
            if (dfs_q) begin
              l_wdata = {cur_t_q, idx_q + CW'(1)};
              cur_t_d = idx6;
              idx_d   = '0;
              state_d = amgt_pkg::S_ROWRD;
            end else begin
              l_wdata = {idx6, CW'(0)};
              idx_d   = idx_q + CW'(1);
            end
          end
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      amgt_pkg::S_POPW: begin
        cur_t_d = l_rdata[LW-1:CW];
        idx_d   = dfs_q ? l_rdata[CW-1:0] : '0;
        state_d = amgt_pkg::S_ROWRD;
      end
      amgt_pkg::S_FIN: begin
        if (emit_ok) begin
          out_vld_d = 1'b1;
          o_node_d  = hold_q;
          o_found_d = 1'b0;
          o_wt_d    = '0;
          o_bad_d   = 1'b0;
          o_last_d  = 1'b1;
          state_d   = amgt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = amgt_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= amgt_pkg::S_IDLE;
      node_count_q <= amgt_pkg::NODE_LIMIT;
      row_vld_q    <= '0;
      out_vld_q    <= 1'b0;
      head_q       <= '0;
      cnt_q        <= '0;
      visited_q    <= '0;
    end else begin
      state_q   <= state_d;
      row_vld_q <= row_vld_d;
      out_vld_q <= out_vld_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      visited_q <= visited_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_a_q   <= cmd_a_d;
    cmd_b_q   <= cmd_b_d;
    dfs_q     <= dfs_d;
    cur_t_q   <= cur_t_d;
    idx_q     <= idx_d;
    hold_q    <= hold_d;
    o_node_q  <= o_node_d;
    o_found_q <= o_found_d;
    o_wt_q    <= o_wt_d;
    o_bad_q   <= o_bad_d;
    o_last_q  <= o_last_d;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.visited_node = o_node_q;
  assign out_o.edge_found   = o_found_q;
  assign out_o.found_weight = o_wt_q;
  assign out_o.bad_start    = o_bad_q;
  assign out_o.last         = o_last_q;

  // checks
  `AMGT_ASSERT_ALWAYS(a_queue_order, head_q <= cnt_q, "queue head passed tail")
  `AMGT_ASSERT_ALWAYS(a_hold_visited, !in_scan || visited_q[hold_q], "held node not visited")
  `AMGT_ASSERT_NEXT(a_find_path, find_acc, state_q == amgt_pkg::S_FIND, "find skipped lookup")

endmodule

### src/amgt_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port, one read port, registered read data held between reads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amgt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### test/amgt_tb_pkg.sv
// ----------------------------------------------------------------------------
// Graph traversal unit testbench package
// Command and result item types shared by the stimulus and checking code
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amgt_tb_pkg;
  import amgt_pkg::*;

  typedef struct packed {
    logic [2:0]                kind;
    logic [NodeW-1:0]          from_node;
    logic [NodeW-1:0]          to_node;
    logic signed [WeightW-1:0] edge_weight;
  } graph_cmd_t;

  typedef struct packed {
    logic [NodeW-1:0]          visited_node;
    logic                      edge_found;
    logic signed [WeightW-1:0] found_weight;
    logic                      bad_start;
    logic                      last;
  } graph_res_t;
endpackage

### test/adjacency_matrix_graph_traversal_unit_tb.sv
// ----------------------------------------------------------------------------
// Graph traversal unit testbench
// Drives commands through the valid/ready channel, predicts every result
// from a behavioural copy of the graph and compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adjacency_matrix_graph_traversal_unit_tb;
  import amgt_pkg::*;
  import amgt_tb_pkg::*;

  localparam int WatchLimit = 200000;
  localparam logic [2:0] KIND_SPARE = 3'd6;
  localparam logic [2:0] KIND_TOP   = 3'd7;

  typedef struct {
    graph_cmd_t cmd;
    logic       has_res;
    graph_res_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CountW-1:0] cfg_data_i = '0;

  amgt_in_if  in_ch();
  amgt_out_if out_ch();

  adjacency_matrix_graph_traversal_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic [MaxNodes-1:0]  pred_edges [MaxNodes];
  logic [WeightW-1:0]   pred_weight [MaxNodes*MaxNodes];
  logic [CountW-1:0]    pred_count;
  graph_res_t           pending_results [$];

  int errors = 0;
  int n_cmds = 0;
  int n_results = 0;
  int n_traversals = 0;
  int idle_cycles = 0;
  logic hold_off = 1'b0;
  logic sink_on = 1'b0;

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.from_node = '0;
    in_ch.to_node = '0;
    in_ch.edge_weight = '0;
    out_ch.ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  function automatic int active_count();
    return (pred_count > NODE_LIMIT) ? MaxNodes : int'(pred_count);
  endfunction

  function automatic logic edge_seen(int a, int b);
    return (a != b) && pred_edges[a][b];
  endfunction

  function automatic graph_res_t mk_res(int node, logic fnd, logic [31:0] w, logic bad);
    graph_res_t r;
    r.visited_node = node[NodeW-1:0];
    r.edge_found = fnd;
    r.found_weight = w;
    r.bad_start = bad;
    r.last = 1'b0;
    return r;
  endfunction

  // behavioural graph: appends expected results for one command
  task automatic predict_graph(input graph_cmd_t c);
    int n, a, b, head, tail, depth, t, i;
    logic [MaxNodes-1:0] seen;
    int wl [MaxNodes];
    int sp [MaxNodes];
    graph_res_t r;
    n = active_count();
    a = c.from_node;
    b = c.to_node;
    case (c.kind)
      KIND_INSERT: begin
        if (a != b && a < n && b < n) begin
          pred_edges[a][b] = 1'b1;
          pred_weight[a*MaxNodes+b] = c.edge_weight;
        end
        return;
      end
      KIND_CLEAR: begin
        for (i = 0; i < MaxNodes; i++) pred_edges[i] = '0;
        return;
      end
      KIND_FIND: begin
        if (a < n && b < n && edge_seen(a, b))
          r = mk_res(0, 1'b1, pred_weight[a*MaxNodes+b], 1'b0);
        else
          r = mk_res(0, 1'b0, '0, 1'b0);
        r.last = 1'b1;
        pending_results.push_back(r);
        return;
      end
      KIND_BFS, KIND_DFS: ;
      default: return;
    endcase
    n_traversals++;
    if (a >= n) begin
      r = mk_res(0, 1'b0, '0, 1'b1);
      r.last = 1'b1;
      pending_results.push_back(r);
      return;
    end
    seen = '0;
    seen[a] = 1'b1;
    pending_results.push_back(mk_res(a, 1'b0, '0, 1'b0));
    if (c.kind == KIND_BFS) begin
      // breadth first over a queue
      head = 0;
      tail = 1;
      wl[0] = a;
      while (head < tail) begin
        t = wl[head];
        head++;
        for (i = 0; i < n; i++) begin
          if (edge_seen(t, i) && !seen[i]) begin
            seen[i] = 1'b1;
            if (tail < MaxNodes) begin
              wl[tail] = i;
              tail++;
            end
            pending_results.push_back(mk_res(i, 1'b0, '0, 1'b0));
          end
        end
      end
    end else begin
      // depth first with a per-level scan position
      wl[0] = a;
      sp[0] = 0;
      depth = 1;
      while (depth > 0) begin
        t = wl[depth-1];
        i = sp[depth-1];
        while (i < n && !(edge_seen(t, i) && !seen[i])) i++;
        if (i < n) begin
          sp[depth-1] = i + 1;
          seen[i] = 1'b1;
          pending_results.push_back(mk_res(i, 1'b0, '0, 1'b0));
          if (depth < MaxNodes) begin
            wl[depth] = i;
            sp[depth] = 0;
            depth++;
          end
        end else begin
          sp[depth-1] = n;
          depth--;
        end
      end
    end
    pending_results[pending_results.size()-1].last = 1'b1;
  endtask

  // one command transfer, driven on the falling edge
  task automatic send_cmd(input graph_cmd_t c);
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.kind <= c.kind;
    in_ch.from_node <= c.from_node;
    in_ch.to_node <= c.to_node;
    in_ch.edge_weight <= c.edge_weight;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_graph(c);
    n_cmds++;
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_count(input int v);
    drain_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v[CountW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pred_count = v[CountW-1:0];
  endtask

  function automatic graph_cmd_t mk_cmd(logic [2:0] k, int a, int b, logic [31:0] w);
    graph_cmd_t c;
    c.kind = k;
    c.from_node = a[NodeW-1:0];
    c.to_node = b[NodeW-1:0];
    c.edge_weight = w;
    return c;
  endfunction

  // random command, mostly inserts among the active vertices
  function automatic graph_cmd_t rand_cmd(int n);
    int p, hi;
    p = $urandom_range(99);
    hi = (n > 0) ? n - 1 : 0;
    if ($urandom_range(9) == 0) hi = 63;
    if (p < 55)
      return mk_cmd(KIND_INSERT, $urandom_range(hi), $urandom_range(hi), $urandom);
    if (p < 72)
      return mk_cmd(KIND_FIND, $urandom_range(hi), $urandom_range(hi), $urandom);
    if (p < 83) return mk_cmd(KIND_BFS, $urandom_range(hi), $urandom_range(63), $urandom);
    if (p < 94) return mk_cmd(KIND_DFS, $urandom_range(hi), $urandom_range(63), $urandom);
    if (p < 97) return mk_cmd(KIND_CLEAR, $urandom_range(63), $urandom_range(63), $urandom);
    return mk_cmd(3'($urandom_range(7, 5)), $urandom_range(63), $urandom_range(63), $urandom);
  endfunction

  // receiver: stall pattern plus a long hold-off counted here
  initial begin
    out_ch.ready = 1'b0;
    wait (sink_on);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      else if ((idle_cycles / 37) % 3 == 0) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(3) != 0);
    end
  end

  // result checking
  always @(posedge clk_i) begin
    graph_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transfer", out_ch.visited_node, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.visited_node !== want.visited_node)
          report_mismatch("visited_node", out_ch.visited_node, want.visited_node);
        if (out_ch.edge_found !== want.edge_found)
          report_mismatch("edge_found", out_ch.edge_found, want.edge_found);
        if (out_ch.found_weight !== want.found_weight)
          report_mismatch("found_weight", out_ch.found_weight, want.found_weight);
        if (out_ch.bad_start !== want.bad_start)
          report_mismatch("bad_start", out_ch.bad_start, want.bad_start);
        if (out_ch.last !== want.last)
          report_mismatch("last", out_ch.last, want.last);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("adjacency_matrix_graph_traversal_unit verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    dir_row_t dir_rows [$];
    dir_row_t row;
    graph_cmd_t c;
    int k, burst, v, gap;
    for (k = 0; k < MaxNodes; k++) pred_edges[k] = '0;
    pred_count = NODE_LIMIT;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    sink_on = 1'b1;

    // directed table: expected result given where obvious
    row.has_res = 1'b1;
    row.cmd = mk_cmd(KIND_FIND, 0, 1, '0); row.res = mk_res(0, 0, '0, 0);
    row.res.last = 1; dir_rows.push_back(row);
    row.cmd = mk_cmd(KIND_BFS, 5, 0, '0); row.res = mk_res(5, 0, '0, 0);
    row.res.last = 1; dir_rows.push_back(row);
    row.has_res = 1'b0;
    dir_rows.push_back('{mk_cmd(KIND_INSERT, 0, 63, 32'h7fffffff), 0, '0});
    dir_rows.push_back('{mk_cmd(KIND_INSERT, 63, 0, 32'h80000000), 0, '0});
    dir_rows.push_back('{mk_cmd(KIND_INSERT, 7, 7, 32'h00010000), 0, '0});
    dir_rows.push_back('{mk_cmd(KIND_INSERT, 0, 2, 32'hffffffff), 0, '0});
    dir_rows.push_back('{mk_cmd(KIND_INSERT, 2, 5, 32'h00008000), 0, '0});
    dir_rows.push_back('{mk_cmd(KIND_INSERT, 63, 5, 32'h12345678), 0, '0});
    row.has_res = 1'b1;
    row.cmd = mk_cmd(KIND_FIND, 0, 63, '0); row.res = mk_res(0, 1, 32'h7fffffff, 0);
    row.res.last = 1; dir_rows.push_back(row);
    row.cmd = mk_cmd(KIND_FIND, 63, 0, '0); row.res = mk_res(0, 1, 32'h80000000, 0);
    row.res.last = 1; dir_rows.push_back(row);
    row.cmd = mk_cmd(KIND_FIND, 7, 7, '0); row.res = mk_res(0, 0, '0, 0);
    row.res.last = 1; dir_rows.push_back(row);
    row.has_res = 1'b0;
    dir_rows.push_back('{mk_cmd(KIND_BFS, 0, 0, '0), 0, '0});
    dir_rows.push_back('{mk_cmd(KIND_DFS, 0, 0, '0), 0, '0});
    dir_rows.push_back('{mk_cmd(KIND_DFS, 63, 0, '0), 0, '0});
    dir_rows.push_back('{mk_cmd(KIND_SPARE, 1, 2, '1), 0, '0});
    dir_rows.push_back('{mk_cmd(KIND_TOP, 63, 63, '1), 0, '0});
    dir_rows.push_back('{mk_cmd(KIND_CLEAR, 0, 0, '0), 0, '0});
    row.has_res = 1'b1;
    row.cmd = mk_cmd(KIND_FIND, 0, 63, '0); row.res = mk_res(0, 0, '0, 0);
    row.res.last = 1; dir_rows.push_back(row);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_res) drain_results();
      send_cmd(dir_rows[i].cmd);
      if (dir_rows[i].has_res) begin
        if (pending_results.size() != 1)
          report_mismatch($sformatf("directed row %0d result count", i),
                          pending_results.size(), 1);
        else if (pending_results[0] !== dir_rows[i].res)
          report_mismatch($sformatf("directed row %0d typed result", i),
                          pending_results[0].found_weight, dir_rows[i].res.found_weight);
      end
    end

    // shrink and out-of-range counts
    write_count(1);
    send_cmd(mk_cmd(KIND_BFS, 0, 0, '0));
    send_cmd(mk_cmd(KIND_DFS, 1, 0, '0));
    write_count(0);
    send_cmd(mk_cmd(KIND_BFS, 0, 0, '0));
    send_cmd(mk_cmd(KIND_FIND, 0, 63, '0));
    write_count(127);
    send_cmd(mk_cmd(KIND_INSERT, 1, 62, 32'h00000001));
    send_cmd(mk_cmd(KIND_DFS, 1, 0, '0));

    // random phases with bursts and gaps
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: v = 8;
        1: v = 64;
        2: v = 2;
        default: v = $urandom_range(64, 1);
      endcase
      write_count(v);
      for (k = 0; k < 34; k++) begin
        burst = $urandom_range(6, 1);
        repeat (burst) begin
          send_cmd(rand_cmd(v));
          k++;
        end
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
        repeat (gap) @(posedge clk_i);
        if (ph == 1 && k > 15 && k < 22) begin
          // long receiver hold-off while commands keep coming
          hold_off = 1'b1;
          send_cmd(mk_cmd(KIND_BFS, 0, 0, '0));
          send_cmd(mk_cmd(KIND_FIND, 1, 2, '0));
          send_cmd(mk_cmd(KIND_DFS, 3, 0, '0));
        end
        if (ph == 2 && k > 20 && k < 28) drain_results();
      end
    end

    drain_results();
    repeat (100) @(posedge clk_i);
    $display("covered %0d commands, %0d traversals, %0d results checked",
             n_cmds, n_traversals, n_results);
    $display("vertex counts 0, 1, 2, 8, 64, 127 and one random; long stall exercised");
    if (errors == 0 && pending_results.size() == 0)
      $display("adjacency_matrix_graph_traversal_unit verification clean");
    else
      $display("adjacency_matrix_graph_traversal_unit verification failed");
    $finish;
  end
endmodule
